[hw/rtl/video_ram_bank_mapper_top_assert.svh]
// assertion macros for the video ram bank mapper
`ifndef VIDEO_RAM_BANK_MAPPER_TOP_ASSERT_SVH
`define VIDEO_RAM_BANK_MAPPER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define VRBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VRBM_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define VRBM_ASSERT(label, prop, msg)
`define VRBM_ASSERT_IMPL(label, pre, post, msg)
`endif

`endif

[hw/rtl/vrbm_pkg.sv]
`timescale 1ns / 1ps

package vrbm_pkg;

    localparam int BANK_COUNT = 9;
    localparam int BANK_IDX_W = 4;
    localparam int OP_W = 4;
    localparam int ADDR_W = 24;
    localparam int PHYS_W = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PHYS_W-1:0] phys_t;
    typedef logic [BANK_IDX_W-1:0] bank_idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // control byte of one bank
    typedef struct packed {
        logic       enable;
        logic [1:0] spare;
        logic [1:0] offset;
        logic [2:0] mode;
    } bank_ctrl_t;

    // requesters
    localparam op_t OP_MAIN        = 4'd0;
    localparam op_t OP_SUB         = 4'd1;
    localparam op_t OP_A_BG        = 4'd2;
    localparam op_t OP_A_OBJ       = 4'd3;
    localparam op_t OP_B_BG        = 4'd4;
    localparam op_t OP_B_OBJ       = 4'd5;
    localparam op_t OP_TEX         = 4'd6;
    localparam op_t OP_TEX_PAL     = 4'd7;
    localparam op_t OP_A_BG_EXT    = 4'd8;
    localparam op_t OP_A_OBJ_EXT   = 4'd9;
    localparam op_t OP_B_BG_EXT    = 4'd10;
    localparam op_t OP_B_OBJ_EXT   = 4'd11;

    // bank modes
    localparam logic [2:0] MODE_0 = 3'd0;
    localparam logic [2:0] MODE_1 = 3'd1;
    localparam logic [2:0] MODE_2 = 3'd2;
    localparam logic [2:0] MODE_3 = 3'd3;
    localparam logic [2:0] MODE_4 = 3'd4;
    localparam logic [2:0] MODE_5 = 3'd5;

    // register indexes
    localparam cfg_idx_t CFG_CTRL_ABCD = 2'd0;
    localparam cfg_idx_t CFG_CTRL_EFG  = 2'd1;
    localparam cfg_idx_t CFG_CTRL_HI   = 2'd2;

    localparam phys_t BANK_BASE [BANK_COUNT] = '{
        20'h00000, 20'h20000, 20'h40000, 20'h60000, 20'h80000,
        20'h90000, 20'h94000, 20'h98000, 20'hA0000
    };

    localparam phys_t BANK_MASK [BANK_COUNT] = '{
        20'h1FFFF, 20'h1FFFF, 20'h1FFFF, 20'h1FFFF, 20'h0FFFF,
        20'h03FFF, 20'h03FFF, 20'h07FFF, 20'h03FFF
    };

    // aligned window test: address and start agree above the window size
    function automatic logic win_hit(input addr_t a, input addr_t start, input int unsigned lg);
        addr_t diff;
        diff = (a ^ start) >> lg;
        return diff == '0;
    endfunction

    // fold the request address into the requester's view
    function automatic addr_t wrap_address(input op_t op, input addr_t addr);
        addr_t    a;
        logic [2:0] slot;
        slot = addr[16:14];
        if (op == OP_MAIN)
        begin
            a = addr;
        end
        else if (op == OP_SUB)
        begin
            a = {6'd0, addr[17:0]};
        end
        else if (op <= OP_TEX)
        begin
            a = {5'd0, addr[18:0]};
        end
        else if (op == OP_TEX_PAL)
        begin
            if (slot >= 3'd6)
            begin
                slot = slot - 3'd6;
            end
            a = {7'd0, slot, addr[13:0]};
        end
        else if (op == OP_A_BG_EXT || op == OP_B_BG_EXT)
        begin
            a = {9'd0, addr[14:0]};
        end
        else
        begin
            a = {11'd0, addr[12:0]};
        end
        return a;
    endfunction

endpackage

[hw/rtl/video_ram_bank_mapper_top.sv]
`timescale 1ns / 1ps

// Video RAM bank mapper: turns one request (requester code on s_tuser, view-relative
// byte address on s_tdata) into a byte address in the combined bank storage, the
// serving bank and a hit flag. One request is taken every cycle while m_tready does not
// stall the output; each result passes through the input register and then the result
// register, with the decode of all nine banks and the last-bank-wins selection between
// them. Bank controls are written through the cfg channel, which is always ready;
// write them only while no request is in flight.

`include "video_ram_bank_mapper_top_assert.svh"

module video_ram_bank_mapper_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  vrbm_pkg::cfg_idx_t          cfg_index,
    input  logic [vrbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // target_address
    input  logic [3:0]                  s_tuser,  // operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // physical_address, bank_index
    output logic                        m_tuser   // hit
);
    import vrbm_pkg::*;

    logic [31:0] ctrl_abcd_reg;
    logic [23:0] ctrl_efg_reg;
    logic [15:0] ctrl_hi_reg;

    logic      in_valid_reg;
    logic      in_valid_next;
    op_t       op_reg;
    addr_t     addr_reg;

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      hit_reg;
    phys_t     phys_reg;
    bank_idx_t bank_reg;

    logic       advance;
    logic       s_accept;
    addr_t      view_addr;
    bank_ctrl_t ctrl [BANK_COUNT];
    logic [BANK_COUNT-1:0] bank_hit;
    logic       any_hit;
    bank_idx_t  win_idx;
    phys_t      phys_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_abcd_reg <= '0;
            ctrl_efg_reg  <= '0;
            ctrl_hi_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CTRL_ABCD: ctrl_abcd_reg <= cfg_data;
                CFG_CTRL_EFG:  ctrl_efg_reg  <= cfg_data[23:0];
                CFG_CTRL_HI:   ctrl_hi_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    assign ctrl[0] = ctrl_abcd_reg[7:0];
    assign ctrl[1] = ctrl_abcd_reg[15:8];
    assign ctrl[2] = ctrl_abcd_reg[23:16];
    assign ctrl[3] = ctrl_abcd_reg[31:24];
    assign ctrl[4] = ctrl_efg_reg[7:0];
    assign ctrl[5] = ctrl_efg_reg[15:8];
    assign ctrl[6] = ctrl_efg_reg[23:16];
    assign ctrl[7] = ctrl_hi_reg[7:0];
    assign ctrl[8] = ctrl_hi_reg[15:8];

    // request flow
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= s_tuser;
            addr_reg <= s_tdata;
        end
        if (advance)
        begin
            hit_reg  <= any_hit;
            phys_reg <= phys_next;
            bank_reg <= win_idx;
        end
    end

    // bank decode
    assign view_addr = wrap_address(op_reg, addr_reg);

    for (genvar b = 0; b < BANK_COUNT; b++)
    begin : g_bank
        vrbm_bank_match #(
            .BANK (b)
        ) u_match (
            .ctrl      (ctrl[b]),
            .operation (op_reg),
            .address   (view_addr),
            .hit       (bank_hit[b])
        );
    end

    // later banks override earlier ones
    always_comb
    begin
        any_hit = 1'b0;
        win_idx = '0;
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            if (bank_hit[b])
            begin
                any_hit = 1'b1;
                win_idx = BANK_IDX_W'(b);
            end
        end
        phys_next = '0;
        if (any_hit)
        begin
            phys_next = BANK_BASE[win_idx] | (view_addr[PHYS_W-1:0] & BANK_MASK[win_idx]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {bank_reg, phys_reg};

    `VRBM_ASSERT_IMPL(a_miss_zero, out_valid_reg && !hit_reg, phys_reg == '0 && bank_reg == '0, "miss with nonzero address or bank")
    `VRBM_ASSERT_IMPL(a_bank_range, out_valid_reg, bank_reg < BANK_IDX_W'(BANK_COUNT), "bank index out of range")
    `VRBM_ASSERT_IMPL(a_no_overwrite, in_valid_reg && out_valid_reg && !m_tready, !s_tready, "input register overwritten while stalled")
    `VRBM_ASSERT(a_moves_on, (in_valid_reg && advance) |=> out_valid_reg, "request lost between input and result register")

endmodule

[hw/rtl/vrbm_bank_match.sv]
`timescale 1ns / 1ps

module vrbm_bank_match #(
    parameter int BANK = 0
) (
    input  vrbm_pkg::bank_ctrl_t ctrl,
    input  vrbm_pkg::op_t        operation,
    input  vrbm_pkg::addr_t      address,
    output logic                 hit
);
    import vrbm_pkg::*;

    localparam addr_t FIXED_AD = 24'h800000 + 24'((BANK < 4) ? BANK : 0) * 24'h20000;
    localparam addr_t FIXED_FG = 24'h890000 + 24'((BANK >= 5) ? BANK - 5 : 0) * 24'h4000;

    addr_t slot_full;
    addr_t slot_half;
    addr_t seg_lo;
    addr_t seg_hi;
    addr_t seg_ext;
    logic  match;

    assign slot_full = {5'd0, ctrl.offset, 17'd0};
    assign slot_half = {6'd0, ctrl.offset[0], 17'd0};
    assign seg_lo    = {7'd0, ctrl.offset[1], 1'b0, ctrl.offset[0], 14'd0};
    assign seg_hi    = {7'd0, 1'b1, 1'b0, ctrl.offset[0], 14'd0};
    assign seg_ext   = {9'd0, ctrl.offset[0], 14'd0};

    always_comb
    begin
        match = 1'b0;
        if (BANK < 4)
        begin
            unique case (ctrl.mode)
                MODE_0: match = operation == OP_MAIN && win_hit(address, FIXED_AD, 17);
                MODE_1: match = (operation == OP_MAIN || operation == OP_A_BG)
                                && win_hit(address, slot_full, 17);
                MODE_2:
                begin
                    if (BANK < 2)
                    begin
                        if (operation == OP_MAIN)
                        begin
                            match = win_hit(address, 24'h400000 | slot_half, 17);
                        end
                        else if (operation == OP_A_OBJ)
                        begin
                            match = win_hit(address, slot_half, 17);
                        end
                    end
                    else
                    begin
                        match = operation == OP_SUB && win_hit(address, slot_half, 17);
                    end
                end
                MODE_3: match = operation == OP_TEX && win_hit(address, slot_full, 17);
                MODE_4:
                begin
                    if (BANK == 2)
                    begin
                        if (operation == OP_MAIN)
                        begin
                            match = win_hit(address, 24'h200000, 17);
                        end
                        else
                        begin
                            match = operation == OP_B_BG && win_hit(address, 24'h0, 17);
                        end
                    end
                    else if (BANK == 3)
                    begin
                        if (operation == OP_MAIN)
                        begin
                            match = win_hit(address, 24'h600000, 17);
                        end
                        else
                        begin
                            match = operation == OP_B_OBJ && win_hit(address, 24'h0, 17);
                        end
                    end
                end
                default: match = 1'b0;
            endcase
        end
        else if (BANK == 4)
        begin
            unique case (ctrl.mode)
                MODE_0: match = operation == OP_MAIN && win_hit(address, 24'h880000, 16);
                MODE_1: match = (operation == OP_MAIN || operation == OP_A_BG)
                                && win_hit(address, 24'h0, 16);
                MODE_2:
                begin
                    if (operation == OP_MAIN)
                    begin
                        match = win_hit(address, 24'h400000, 16);
                    end
                    else
                    begin
                        match = operation == OP_A_OBJ && win_hit(address, 24'h0, 16);
                    end
                end
                MODE_3: match = operation == OP_TEX_PAL && win_hit(address, 24'h0, 16);
                MODE_4: match = operation == OP_A_BG_EXT && win_hit(address, 24'h0, 15);
                default: match = 1'b0;
            endcase
        end
        else if (BANK < 7)
        begin
            unique case (ctrl.mode)
                MODE_0: match = operation == OP_MAIN && win_hit(address, FIXED_FG, 14);
                MODE_1: match = (operation == OP_MAIN || operation == OP_A_BG)
                                && (win_hit(address, seg_lo, 14) || win_hit(address, seg_hi, 14));
                MODE_2:
                begin
                    if (operation == OP_MAIN)
                    begin
                        match = win_hit(address, 24'h400000 | seg_lo, 14)
                                || win_hit(address, 24'h400000 | seg_hi, 14);
                    end
                    else if (operation == OP_A_OBJ)
                    begin
                        match = win_hit(address, seg_lo, 14) || win_hit(address, seg_hi, 14);
                    end
                end
                // palette slot: offset bit 0 picks 16KB, bit 1 picks 64KB
                MODE_3: match = operation == OP_TEX_PAL && win_hit(address, seg_lo, 14);
                MODE_4: match = operation == OP_A_BG_EXT && win_hit(address, seg_ext, 14);
                MODE_5: match = operation == OP_A_OBJ_EXT;
                default: match = 1'b0;
            endcase
        end
        else if (BANK == 7)
        begin
            unique case (ctrl.mode)
                MODE_0: match = operation == OP_MAIN && win_hit(address, 24'h898000, 15);
                MODE_1:
                begin
                    if (operation == OP_MAIN)
                    begin
                        match = win_hit(address, 24'h200000, 15)
                                || win_hit(address, 24'h210000, 15);
                    end
                    else if (operation == OP_B_BG)
                    begin
                        match = win_hit(address, 24'h0, 15) || win_hit(address, 24'h10000, 15);
                    end
                end
                MODE_2: match = operation == OP_B_BG_EXT && win_hit(address, 24'h0, 15);
                default: match = 1'b0;
            endcase
        end
        else
        begin
            unique case (ctrl.mode)
                MODE_0: match = operation == OP_MAIN && win_hit(address, 24'h8A0000, 14);
                MODE_1:
                begin
                    if (operation == OP_MAIN)
                    begin
                        match = win_hit(address, 24'h208000, 14)
                                || win_hit(address, 24'h218000, 14);
                    end
                    else if (operation == OP_B_BG)
                    begin
                        match = win_hit(address, 24'h8000, 14)
                                || win_hit(address, 24'h18000, 14);
                    end
                end
                MODE_2:
                begin
                    if (operation == OP_MAIN)
                    begin
                        match = win_hit(address, 24'h600000, 17);
                    end
                    else
                    begin
                        match = operation == OP_B_OBJ && win_hit(address, 24'h0, 17);
                    end
                end
                MODE_3: match = operation == OP_B_OBJ_EXT;
                default: match = 1'b0;
            endcase
        end
    end

    assign hit = ctrl.enable && match;

endmodule

[bench/video_ram_bank_mapper_top_test.sv]
`timescale 1ns / 1ps

module video_ram_bank_mapper_top_test;

    import vrbm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_REQUESTS = 112;

    localparam addr_t MAIN_REGIONS [14] = '{
        24'h000000, 24'h020000, 24'h040000, 24'h060000, 24'h200000, 24'h210000, 24'h400000,
        24'h420000, 24'h600000, 24'h800000, 24'h840000, 24'h880000, 24'h890000, 24'h8A0000
    };

    typedef struct packed {
        op_t       op;
        addr_t     addr;
        logic      hit;
        phys_t     phys;
        bank_idx_t bank;
    } translation_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_CTRL_ABCD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;   // target_address
    logic [3:0]            s_tuser = '0;   // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;        // physical_address, bank_index
    logic                  m_tuser;        // hit

    logic [31:0] ctl_abcd = '0;
    logic [23:0] ctl_efg = '0;
    logic [15:0] ctl_hi = '0;

    translation_t pending_translations [$];
    translation_t due_result;
    logic         send_gaps = 1'b1;
    logic         recv_gaps = 1'b1;
    int           error_count = 0;
    int           cycle_count = 0;

    video_ram_bank_mapper_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic in_range(input addr_t a, input addr_t start, input addr_t len);
        return (a >= start) && ((a - start) < len);
    endfunction

    function automatic logic in_either(input addr_t a, input addr_t s1, input addr_t s2,
                                       input addr_t len, output addr_t start);
        start = s1;
        if (in_range(a, s1, len))
            return 1'b1;
        start = s2;
        return in_range(a, s2, len);
    endfunction

    // does bank b, with this mode and offset, map view address a for requester op
    function automatic logic bank_maps(input int unsigned b, input logic [2:0] mode,
                                       input logic [1:0] ofs, input op_t op, input addr_t a,
                                       output addr_t start);
        addr_t o;
        addr_t o2;
        addr_t len;
        start = '0;
        o = {7'd0, ofs[1], 1'b0, ofs[0], 14'd0};
        o2 = {7'd0, 1'b1, 1'b0, ofs[0], 14'd0};
        if (b < 4)
        begin
            len = 24'h020000;
            case (mode)
                MODE_0:
                begin
                    start = 24'h800000 + addr_t'(b) * 24'h020000;
                    return op == OP_MAIN && in_range(a, start, len);
                end
                MODE_1:
                begin
                    start = {5'd0, ofs, 17'd0};
                    return (op == OP_MAIN || op == OP_A_BG) && in_range(a, start, len);
                end
                MODE_2:
                begin
                    start = {6'd0, ofs[0], 17'd0};
                    if (b >= 2)
                        return op == OP_SUB && in_range(a, start, len);
                    if (op == OP_MAIN)
                        start = start + 24'h400000;
                    return (op == OP_MAIN || op == OP_A_OBJ) && in_range(a, start, len);
                end
                MODE_3:
                begin
                    start = {5'd0, ofs, 17'd0};
                    return op == OP_TEX && in_range(a, start, len);
                end
                MODE_4:
                begin
                    if (b < 2)
                        return 1'b0;
                    if (op == OP_MAIN)
                        start = (b == 2) ? 24'h200000 : 24'h600000;
                    return (op == OP_MAIN || op == ((b == 2) ? OP_B_BG : OP_B_OBJ))
                           && in_range(a, start, len);
                end
                default: return 1'b0;
            endcase
        end
        else if (b == 4)
        begin
            len = 24'h010000;
            case (mode)
                MODE_0:
                begin
                    start = 24'h880000;
                    return op == OP_MAIN && in_range(a, start, len);
                end
                MODE_1: return (op == OP_MAIN || op == OP_A_BG) && in_range(a, start, len);
                MODE_2:
                begin
                    if (op == OP_MAIN)
                        start = 24'h400000;
                    return (op == OP_MAIN || op == OP_A_OBJ) && in_range(a, start, len);
                end
                MODE_3: return op == OP_TEX_PAL && in_range(a, start, len);
                MODE_4: return op == OP_A_BG_EXT && in_range(a, start, 24'h008000);
                default: return 1'b0;
            endcase
        end
        else if (b < 7)
        begin
            len = 24'h004000;
            case (mode)
                MODE_0:
                begin
                    start = (b == 5) ? 24'h890000 : 24'h894000;
                    return op == OP_MAIN && in_range(a, start, len);
                end
                MODE_1:
                begin
                    if (op != OP_MAIN && op != OP_A_BG)
                        return 1'b0;
                    return in_either(a, o, o2, len, start);
                end
                MODE_2:
                begin
                    if (op == OP_MAIN)
                        return in_either(a, o + 24'h400000, o2 + 24'h400000, len, start);
                    if (op == OP_A_OBJ)
                        return in_either(a, o, o2, len, start);
                    return 1'b0;
                end
                MODE_3:
                begin
                    start = o;
                    return op == OP_TEX_PAL && in_range(a, start, len);
                end
                MODE_4:
                begin
                    start = {9'd0, ofs[0], 14'd0};
                    return op == OP_A_BG_EXT && in_range(a, start, len);
                end
                MODE_5: return op == OP_A_OBJ_EXT;
                default: return 1'b0;
            endcase
        end
        else if (b == 7)
        begin
            len = 24'h008000;
            case (mode)
                MODE_0:
                begin
                    start = 24'h898000;
                    return op == OP_MAIN && in_range(a, start, len);
                end
                MODE_1:
                begin
                    if (op == OP_MAIN)
                        return in_either(a, 24'h200000, 24'h210000, len, start);
                    if (op == OP_B_BG)
                        return in_either(a, 24'h000000, 24'h010000, len, start);
                    return 1'b0;
                end
                MODE_2: return op == OP_B_BG_EXT && in_range(a, start, len);
                default: return 1'b0;
            endcase
        end
        else
        begin
            len = 24'h004000;
            case (mode)
                MODE_0:
                begin
                    start = 24'h8A0000;
                    return op == OP_MAIN && in_range(a, start, len);
                end
                MODE_1:
                begin
                    if (op == OP_MAIN)
                        return in_either(a, 24'h208000, 24'h218000, len, start);
                    if (op == OP_B_BG)
                        return in_either(a, 24'h008000, 24'h018000, len, start);
                    return 1'b0;
                end
                MODE_2:
                begin
                    if (op == OP_MAIN)
                        start = 24'h600000;
                    return (op == OP_MAIN || op == OP_B_OBJ) && in_range(a, start, 24'h020000);
                end
                MODE_3: return op == OP_B_OBJ_EXT;
                default: return 1'b0;
            endcase
        end
        return 1'b0;
    endfunction

    function automatic translation_t predict_translation(input op_t op, input addr_t addr);
        translation_t r;
        addr_t        a;
        addr_t        start;
        logic [2:0]   slot;
        logic [71:0]  controls;
        bank_ctrl_t   c;
        int unsigned  b;
        r = '0;
        r.op = op;
        r.addr = addr;
        controls = {ctl_hi, ctl_efg, ctl_abcd};
        slot = addr[16:14];
        // fold into the requester's view
        if (op == OP_MAIN)
            a = addr;
        else if (op == OP_SUB)
            a = addr & 24'h03FFFF;
        else if (op <= OP_TEX)
            a = addr & 24'h07FFFF;
        else if (op == OP_TEX_PAL)
        begin
            if (slot >= 3'd6)
                slot = slot - 3'd6;
            a = {7'd0, slot, addr[13:0]};
        end
        else if (op == OP_A_BG_EXT || op == OP_B_BG_EXT)
            a = addr & 24'h007FFF;
        else
            a = addr & 24'h001FFF;
        if (op <= OP_B_OBJ_EXT)
        begin
            // later banks win
            for (b = 0; b < BANK_COUNT; b++)
            begin
                c = controls[8*b +: 8];
                if (c.enable && bank_maps(b, c.mode, c.offset, op, a, start))
                begin
                    r.hit = 1'b1;
                    r.bank = bank_idx_t'(b);
                    r.phys = BANK_BASE[b] + (phys_t'(a - start) & BANK_MASK[b]);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_request(input op_t op, input addr_t addr);
        while (send_gaps && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        pending_translations.push_back(predict_translation(op, addr));
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_translations.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_control(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CTRL_ABCD: ctl_abcd = value;
            CFG_CTRL_EFG:  ctl_efg = value[23:0];
            CFG_CTRL_HI:   ctl_hi = value[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] abcd, input logic [31:0] efg,
                             input logic [31:0] hi);
        drain_requests();
        write_control(CFG_CTRL_ABCD, abcd);
        write_control(CFG_CTRL_EFG, efg);
        write_control(CFG_CTRL_HI, hi);
    endtask

    function automatic logic [31:0] random_controls();
        logic [31:0] w;
        bank_ctrl_t  c;
        int          i;
        for (i = 0; i < 4; i++)
        begin
            c.enable = ($urandom_range(99) < 80);
            c.spare = 2'($urandom);
            c.offset = 2'($urandom);
            c.mode = ($urandom_range(99) < 85) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
            w[8*i +: 8] = c;
        end
        return w;
    endfunction

    task automatic send_random_request();
        op_t   op;
        addr_t addr;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 8)
            op = op_t'($urandom_range(15, 12));
        else if (pick < 33)
            op = OP_MAIN;
        else
            op = op_t'($urandom_range(11, 1));
        if (op == OP_MAIN && $urandom_range(99) >= 15)
            addr = MAIN_REGIONS[$urandom_range(13)] + addr_t'($urandom_range(24'h1FFFF));
        else
            addr = addr_t'($urandom);
        send_request(op, addr);
    endtask

    // every bank disabled out of reset
    task automatic test_after_reset();
        send_request(OP_MAIN, 24'h000000);
        send_request(OP_MAIN, 24'hFFFFFF);
        send_request(OP_B_OBJ_EXT, 24'h001FFF);
        send_request(OP_TEX, 24'h123456);
    endtask

    task automatic test_directed_map();
        // a mode 1, b mode 2 offset 1, c mode 4, d mode 3 offset 3
        // e mode 3, f mode 3 offset 1, g mode 5, h mode 2, i mode 3
        configure(32'h9B848A81, 32'h00858B83, 32'h00008382);
        send_request(OP_MAIN, 24'h000000);
        send_request(OP_MAIN, 24'hFFFFFF);
        send_request(OP_MAIN, 24'h43FFFF);
        send_request(OP_SUB, 24'hFC0000);
        send_request(OP_A_BG, 24'hF81234);
        send_request(OP_A_OBJ, 24'h020010);
        send_request(OP_B_BG, 24'h01FFFF);
        send_request(OP_B_OBJ, 24'h000000);
        send_request(OP_TEX, 24'hF7FFFF);
        // palette slots six and seven alias slots zero and one
        send_request(OP_TEX_PAL, 24'h018000);
        send_request(OP_TEX_PAL, 24'h01C010);
        send_request(OP_TEX_PAL, 24'h00FFFF);
        send_request(OP_A_BG_EXT, 24'h000000);
        send_request(OP_A_OBJ_EXT, 24'hFFFFFF);
        send_request(OP_B_BG_EXT, 24'hFFFFFF);
        send_request(OP_B_OBJ_EXT, 24'h001000);
        send_request(op_t'(12), 24'h000000);
        send_request(op_t'(15), 24'hFFFFFF);
    endtask

    // modes with no meaning for the bank map nothing
    task automatic test_unlisted_modes();
        configure(32'hFFFE8584, 32'h0087E685, 32'h00008483);
        send_request(OP_MAIN, 24'h800000);
        send_request(OP_A_OBJ, 24'h000000);
        send_request(OP_A_OBJ_EXT, 24'h000100);
        send_request(OP_TEX_PAL, 24'h000000);
        send_request(OP_B_BG_EXT, 24'h000000);
        send_request(OP_B_OBJ, 24'h000000);
    endtask

    task automatic test_extreme_controls();
        int n;
        configure(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        for (n = 0; n < 20; n++)
            send_random_request();
        configure(32'h00000000, 32'h00000000, 32'h00000000);
        for (n = 0; n < 20; n++)
            send_random_request();
    endtask

    task automatic test_random_maps();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure(random_controls(), random_controls(), random_controls());
            send_gaps = (phase != 2);
            recv_gaps = (phase != 2);
            for (n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (n == PHASE_REQUESTS / 2)
                    drain_requests();
                send_random_request();
            end
            send_gaps = 1'b1;
            recv_gaps = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        if (recv_gaps)
            m_tready <= ($urandom_range(99) >= 34);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_translations.size() == 0)
                report_mismatch($sformatf("unexpected result hit %0b addr %05h bank %0d",
                                          m_tuser, m_tdata[19:0], m_tdata[23:20]));
            else
            begin
                due_result = pending_translations.pop_front();
                if (m_tuser !== due_result.hit)
                    report_mismatch($sformatf("op %0d addr %06h: hit %0b, want %0b",
                                              due_result.op, due_result.addr, m_tuser,
                                              due_result.hit));
                if (m_tdata[19:0] !== due_result.phys)
                    report_mismatch($sformatf("op %0d addr %06h: physical %05h, want %05h",
                                              due_result.op, due_result.addr, m_tdata[19:0],
                                              due_result.phys));
                if (m_tdata[23:20] !== due_result.bank)
                    report_mismatch($sformatf("op %0d addr %06h: bank %0d, want %0d",
                                              due_result.op, due_result.addr, m_tdata[23:20],
                                              due_result.bank));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_directed_map();
        test_unlisted_modes();
        test_extreme_controls();
        test_random_maps();
        drain_requests();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[video_ram_bank_mapper_top.f]
+incdir+hw/rtl
hw/rtl/vrbm_pkg.sv
hw/rtl/vrbm_bank_match.sv
hw/rtl/video_ram_bank_mapper_top.sv
bench/video_ram_bank_mapper_top_test.sv
